>>> design/assert_macros.svh
// assertion helpers shared by the design files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define ASSERT_CHECK(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("design check failed");
// condition must never be seen at a clock edge outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_CHECK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

>>> design/pcbp_pkg.sv
package pcbp_pkg;

	// polynomial length and index of its final coefficient
	localparam int POLY_DEGREE = 512;
	localparam int CTR_W = 10;
	localparam logic [CTR_W-1:0] LAST_IDX = CTR_W'((POLY_DEGREE - 1) % (1 << CTR_W));

	// datapath widths
	localparam int ACC_W   = 18;
	localparam int CNT_W   = 5;
	localparam int FW_W    = 4;
	localparam int OFS_W   = 7;
	localparam int COEFF_W = 12;
	localparam int BYTE_W  = 8;
	localparam int VAL_W   = 11;
	localparam int NRES_W  = 3;

	// decoupling queue
	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int QCNT_W = 3;

	// supported offset constants
	localparam logic [OFS_W-1:0] OFS_ONE = 7'd1;
	localparam logic [OFS_W-1:0] OFS_TWO = 7'd2;
	localparam logic [OFS_W-1:0] OFS_16  = 7'd16;
	localparam logic [OFS_W-1:0] OFS_32  = 7'd32;
	localparam logic [OFS_W-1:0] OFS_64  = 7'd64;

	localparam logic DIR_PACK   = 1'b0;
	localparam logic DIR_UNPACK = 1'b1;

	// register indexes
	typedef enum logic [1:0] {
		REG_DIRECTION    = 2'd0,
		REG_FIELD_WIDTH  = 2'd1,
		REG_OFFSET_MODE  = 2'd2,
		REG_OFFSET_VALUE = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic             direction;
		logic [FW_W-1:0]  field_width;
		logic             offset_mode;
		logic [OFS_W-1:0] offset_value;
	} cfg_t;

	// one batch of results handed from front to back
	typedef struct packed {
		logic              err;
		logic [ACC_W-1:0]  bits;
		logic [NRES_W-1:0] nres;
		logic              last;
	} entry_t;

	// width and offset combinations the stream format allows
	function automatic logic config_ok(cfg_t c);
		logic ok;
		ok = 1'b0;
		if (c.offset_mode) begin
			unique case (c.field_width)
				4'd2:    ok = (c.offset_value == OFS_ONE) || (c.offset_value == OFS_TWO);
				4'd5:    ok = (c.offset_value == OFS_16);
				4'd6:    ok = (c.offset_value == OFS_32);
				4'd7:    ok = (c.offset_value == OFS_64);
				default: ok = 1'b0;
			endcase
		end else begin
			unique case (c.field_width)
				4'd9, 4'd10, 4'd11: ok = 1'b1;
				4'd1, 4'd4, 4'd5:   ok = (c.direction == DIR_PACK);
				default:            ok = 1'b0;
			endcase
		end
		return ok;
	endfunction

	// low w bits set
	function automatic logic [VAL_W-1:0] width_mask(logic [FW_W-1:0] w);
		logic [COEFF_W-1:0] m;
		m = (COEFF_W'(1) << w) - COEFF_W'(1);
		return m[VAL_W-1:0];
	endfunction

endpackage

>>> design/pcbp_ifs.sv
// coefficient or byte stream into the block
interface pcbp_feed_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [pcbp_pkg::COEFF_W-1:0]  coeff_in;
	logic        [pcbp_pkg::BYTE_W-1:0]   byte_in;

	modport source (output valid, coeff_in, byte_in, input ready);
	modport sink   (input valid, coeff_in, byte_in, output ready);
endinterface

// result stream out of the block
interface pcbp_result_if;
	logic                                 valid;
	logic                                 ready;
	logic        [pcbp_pkg::BYTE_W-1:0]   byte_out;
	logic signed [pcbp_pkg::COEFF_W-1:0]  coeff_out;
	logic                                 last_of_poly;
	logic                                 config_error;

	modport source (output valid, byte_out, coeff_out, last_of_poly, config_error,
		input ready);
	modport sink   (input valid, byte_out, coeff_out, last_of_poly, config_error,
		output ready);
endinterface

// register write channel
interface pcbp_cfg_if;
	logic                          valid;
	logic                          ready;
	pcbp_pkg::reg_idx_t            index;
	logic [pcbp_pkg::OFS_W-1:0]    data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

>>> design/pcbp_cfg_regs.sv
module pcbp_cfg_regs (
	input  logic          clk,
	input  logic          arst_n,
	pcbp_cfg_if.sink      cfg,
	output pcbp_pkg::cfg_t cfg_o,
	output logic          clear_o
);
	import pcbp_pkg::*;

	cfg_t cfg_q;
	logic wr;

	assign cfg.ready = 1'b1;
	assign wr        = cfg.valid & cfg.ready;
	// every write restarts the polynomial
	assign clear_o   = wr;
	assign cfg_o     = cfg_q;

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.direction    <= DIR_PACK;
			cfg_q.field_width  <= 4'd9;
			cfg_q.offset_mode  <= 1'b0;
			cfg_q.offset_value <= '0;
		end else if (wr) begin
			unique case (cfg.index)
				REG_DIRECTION:    cfg_q.direction    <= cfg.data[0];
				REG_FIELD_WIDTH:  cfg_q.field_width  <= cfg.data[FW_W-1:0];
				REG_OFFSET_MODE:  cfg_q.offset_mode  <= cfg.data[0];
				REG_OFFSET_VALUE: cfg_q.offset_value <= cfg.data;
				default:          cfg_q              <= cfg_q;
			endcase
		end
	end

endmodule

>>> design/pcbp_front.sv
`include "assert_macros.svh"

module pcbp_front (
	input  logic            clk,
	input  logic            arst_n,
	pcbp_feed_if.sink       feed,
	input  pcbp_pkg::cfg_t  cfg,
	input  logic            clear,
	input  logic            q_full,
	output logic            push,
	output pcbp_pkg::entry_t push_entry
);
	import pcbp_pkg::*;

	logic [ACC_W-1:0] acc_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CTR_W-1:0] ctr_q;

	logic             accept;
	logic             ok;
	logic             at_end;
	logic [VAL_W-1:0] mask;
	logic [CNT_W-1:0] w5;
	logic             cnt_ok;

	logic [COEFF_W-1:0] cin;
	logic [COEFF_W-1:0] cin_ofs;
	logic [VAL_W-1:0]   pval;
	logic [ACC_W-1:0]   pk_acc;
	logic [CNT_W-1:0]   pk_cnt;
	logic               pk_flush;
	logic [NRES_W-1:0]  pk_nres;
	logic [ACC_W-1:0]   pk_rest_acc;
	logic [CNT_W-1:0]   pk_rest_cnt;

	logic [ACC_W-1:0]   up_acc;
	logic [5:0]         up_cnt;
	logic [5:0]         m1, m2, m3, m4;
	logic [NRES_W-1:0]  up_fit;
	logic [CTR_W-1:0]   rem;
	logic               up_last;
	logic [NRES_W-1:0]  up_nres;
	logic [5:0]         used;
	logic [ACC_W-1:0]   up_rest_acc;
	logic [CNT_W-1:0]   up_rest_cnt;

	assign feed.ready = !q_full;
	assign accept     = feed.valid & feed.ready;
	assign ok         = config_ok(cfg);
	assign mask       = width_mask(cfg.field_width);
	assign w5         = {1'b0, cfg.field_width};
	assign at_end     = (ctr_q == LAST_IDX);

	// pack: value to append, bytes that become complete
	assign cin         = feed.coeff_in;
	assign cin_ofs     = {{(COEFF_W-OFS_W){1'b0}}, cfg.offset_value} - cin;
	assign pval        = (cfg.offset_mode ? cin_ofs[VAL_W-1:0] : cin[VAL_W-1:0]) & mask;
	assign pk_acc      = acc_q | (ACC_W'(pval) << cnt_q);
	assign pk_cnt      = cnt_q + w5;
	assign pk_flush    = at_end && (pk_cnt[2:0] != 3'd0);
	assign pk_nres     = {1'b0, pk_cnt[4:3]} + {2'b0, pk_flush};
	assign pk_rest_acc = pk_acc >> {pk_cnt[4:3], 3'b000};
	assign pk_rest_cnt = {2'b00, pk_cnt[2:0]};

	// unpack: fields that the new byte completes
	assign up_acc = acc_q | (ACC_W'(feed.byte_in) << cnt_q);
	assign up_cnt = {1'b0, cnt_q} + 6'd8;
	assign m1     = {2'b00, cfg.field_width};
	assign m2     = {1'b0, cfg.field_width, 1'b0};
	assign m3     = m2 + m1;
	assign m4     = {cfg.field_width, 2'b00};
	assign up_fit = {2'b00, up_cnt >= m1} + {2'b00, up_cnt >= m2}
		+ {2'b00, up_cnt >= m3} + {2'b00, up_cnt >= m4};
	assign rem     = LAST_IDX - ctr_q;
	assign up_last = (up_fit != '0) && ({{(CTR_W-NRES_W){1'b0}}, up_fit} > rem);
	assign up_nres = up_last ? (rem[NRES_W-1:0] + NRES_W'(1)) : up_fit;

	// bits taken by the emitted fields
	always_comb begin
		unique case (up_nres)
			3'd1:    used = m1;
			3'd2:    used = m2;
			3'd3:    used = m3;
			3'd4:    used = m4;
			default: used = '0;
		endcase
	end

	assign up_rest_acc = up_acc >> used;
	assign up_rest_cnt = CNT_W'(up_cnt - used);

	// classify the item into a result batch
	always_comb begin
		push_entry = '0;
		push       = 1'b0;
		if (accept) begin
			if (!ok) begin
				push            = 1'b1;
				push_entry.err  = 1'b1;
				push_entry.nres = NRES_W'(1);
			end else if (cfg.direction == DIR_PACK) begin
				push            = (pk_nres != '0);
				push_entry.bits = pk_acc;
				push_entry.nres = pk_nres;
				push_entry.last = at_end;
			end else begin
				push            = (up_nres != '0);
				push_entry.bits = up_acc;
				push_entry.nres = up_nres;
				push_entry.last = up_last;
			end
		end
	end

	// stream state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			cnt_q <= '0;
			ctr_q <= '0;
		end else if (clear) begin
			acc_q <= '0;
			cnt_q <= '0;
			ctr_q <= '0;
		end else if (accept && ok) begin
			if (cfg.direction == DIR_PACK) begin
				if (at_end) begin
					acc_q <= '0;
					cnt_q <= '0;
					ctr_q <= '0;
				end else begin
					acc_q <= pk_rest_acc;
					cnt_q <= pk_rest_cnt;
					ctr_q <= ctr_q + CTR_W'(1);
				end
			end else begin
				if (up_last) begin
					acc_q <= '0;
					cnt_q <= '0;
					ctr_q <= '0;
				end else begin
					acc_q <= up_rest_acc;
					cnt_q <= up_rest_cnt;
					ctr_q <= ctr_q + CTR_W'(up_nres);
				end
			end
		end
	end

	// leftover bits never reach a full byte or a full field
	assign cnt_ok = (cfg.direction == DIR_PACK) ? (cnt_q < 5'd8)
		: ((cnt_q == '0) || (cnt_q < w5));

	`ASSERT_CHECK(a_cnt_bound, clk, arst_n, cnt_ok)

endmodule

>>> design/pcbp_queue.sv
`include "assert_macros.svh"

module pcbp_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  pcbp_pkg::entry_t push_entry,
	input  logic             pop,
	output logic             full,
	output logic             valid,
	output pcbp_pkg::entry_t head
);
	import pcbp_pkg::*;

	entry_t            slot_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_pop;

	assign full   = (count_q == QCNT_W'(QDEPTH));
	assign valid  = (count_q != '0);
	assign head   = slot_q[rd_q];
	assign do_pop = pop & valid;

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_entry;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_q <= rd_q + QPTR_W'(1);
			end
			count_q <= count_q + QCNT_W'(push) - QCNT_W'(do_pop);
		end
	end

	`ASSERT_NEVER(a_q_overflow, clk, arst_n, push && full && !pop)
	`ASSERT_CHECK(a_q_level, clk, arst_n, count_q <= QCNT_W'(QDEPTH))

endmodule

>>> design/pcbp_back.sv
`include "assert_macros.svh"

module pcbp_back (
	input  logic             clk,
	input  logic             arst_n,
	input  pcbp_pkg::cfg_t   cfg,
	input  logic             q_valid,
	input  pcbp_pkg::entry_t q_head,
	output logic             pop,
	pcbp_result_if.source    result
);
	import pcbp_pkg::*;

	entry_t              work_q;
	logic                work_valid_q;
	logic                out_valid_q;
	logic [BYTE_W-1:0]   byte_q;
	logic [COEFF_W-1:0]  coeff_q;
	logic                last_q;
	logic                err_q;

	logic               out_free;
	logic               emit;
	logic               work_done;
	logic [VAL_W-1:0]   fval;
	logic [COEFF_W-1:0] fval_ofs;
	logic [COEFF_W-1:0] coeff_d;
	logic [BYTE_W-1:0]  byte_d;
	logic [ACC_W-1:0]   next_bits;

	assign out_free  = !out_valid_q | result.ready;
	assign emit      = work_valid_q & out_free;
	assign work_done = emit & (work_q.nres == NRES_W'(1));
	assign pop       = q_valid & (!work_valid_q | work_done);

	// current field or byte of the batch
	assign fval     = work_q.bits[VAL_W-1:0] & width_mask(cfg.field_width);
	assign fval_ofs = {{(COEFF_W-OFS_W){1'b0}}, cfg.offset_value} - {1'b0, fval};
	always_comb begin
		byte_d  = '0;
		coeff_d = '0;
		if (!work_q.err) begin
			if (cfg.direction == DIR_PACK) begin
				byte_d = work_q.bits[BYTE_W-1:0];
			end else begin
				coeff_d = cfg.offset_mode ? fval_ofs : {1'b0, fval};
			end
		end
	end
	assign next_bits = (cfg.direction == DIR_PACK) ? (work_q.bits >> BYTE_W)
		: (work_q.bits >> cfg.field_width);

	// batch being drained
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			work_valid_q <= 1'b0;
		end else if (pop) begin
			work_valid_q <= 1'b1;
		end else if (work_done) begin
			work_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			work_q <= q_head;
		end else if (emit) begin
			work_q.bits <= next_bits;
			work_q.nres <= work_q.nres - NRES_W'(1);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			byte_q  <= byte_d;
			coeff_q <= coeff_d;
			last_q  <= work_q.last & (work_q.nres == NRES_W'(1));
			err_q   <= work_q.err;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.byte_out     = byte_q;
	assign result.coeff_out    = coeff_q;
	assign result.last_of_poly = last_q;
	assign result.config_error = err_q;

	`ASSERT_CHECK(a_work_nonempty, clk, arst_n, work_valid_q |-> (work_q.nres != '0))
	`ASSERT_CHECK(a_pop_loads, clk, arst_n, pop |=> work_valid_q)

endmodule

>>> design/poly_coeff_bit_packer.sv
// path: an accepted item goes through the queue and the work register to the output register
// throughput: one item per cycle while each item yields at most one result and the receiver
// is ready; an item with several results holds the drain, a four-entry queue absorbs bursts
// reset: arst_n clears stream state, queue and output; registers return to pack mode,
// width 9, offset mode off, offset 0
module poly_coeff_bit_packer (
	input  logic          clk,
	input  logic          arst_n,
	pcbp_feed_if.sink     feed,
	pcbp_result_if.source result,
	pcbp_cfg_if.sink      cfg
);
	import pcbp_pkg::*;

	cfg_t   cfg_cur;
	logic   clear;
	logic   push;
	entry_t push_entry;
	logic   pop;
	logic   q_full;
	logic   q_valid;
	entry_t q_head;

	pcbp_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.cfg_o   (cfg_cur),
		.clear_o (clear)
	);

	pcbp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.feed       (feed),
		.cfg        (cfg_cur),
		.clear      (clear),
		.q_full     (q_full),
		.push       (push),
		.push_entry (push_entry)
	);

	pcbp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.full       (q_full),
		.valid      (q_valid),
		.head       (q_head)
	);

	pcbp_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_cur),
		.q_valid (q_valid),
		.q_head  (q_head),
		.pop     (pop),
		.result  (result)
	);

endmodule

>>> verif/poly_coeff_bit_packer_test.sv
module poly_coeff_bit_packer_test;
	import pcbp_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int TAIL_CYCLES  = 8;
	localparam int RANDOM_ITEMS = 100;
	localparam int HOLD_CYCLES  = 60;

	// receiver behavior between items
	typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_t;

	// one result as the block should present it
	typedef struct packed {
		logic [BYTE_W-1:0]  byte_val;
		logic [COEFF_W-1:0] coeff_val;
		logic               last;
		logic               err;
	} packer_out_t;

	// tracks registers and stream state, predicts and checks results
	class bitpack_predictor;
		logic             dir;
		logic [FW_W-1:0]  width;
		logic             ofs_mode;
		logic [OFS_W-1:0] ofs;
		logic [ACC_W-1:0] acc;
		logic [CNT_W-1:0] nbits;
		logic [CTR_W-1:0] ncoeff;
		packer_out_t      owed[$];
		int               mismatches;
		int               results_seen;
		int               lasts_seen;
		int               errors_seen;

		function new();
			dir = DIR_PACK;
			width = 4'd9;
			ofs_mode = 1'b0;
			ofs = '0;
			clear_stream();
			mismatches = 0;
			results_seen = 0;
			lasts_seen = 0;
			errors_seen = 0;
		endfunction

		function void clear_stream();
			acc = '0;
			nbits = '0;
			ncoeff = '0;
		endfunction

		// any register write restarts the polynomial
		function void write_reg(reg_idx_t idx, logic [OFS_W-1:0] d);
			case (idx)
				REG_DIRECTION:    dir = d[0];
				REG_FIELD_WIDTH:  width = d[FW_W-1:0];
				REG_OFFSET_MODE:  ofs_mode = d[0];
				REG_OFFSET_VALUE: ofs = d;
			endcase
			clear_stream();
		endfunction

		// width and offset pairs the stream format allows
		function bit supported();
			if (ofs_mode) begin
				case (width)
					4'd2:    return ofs == OFS_ONE || ofs == OFS_TWO;
					4'd5:    return ofs == OFS_16;
					4'd6:    return ofs == OFS_32;
					4'd7:    return ofs == OFS_64;
					default: return 1'b0;
				endcase
			end
			case (width)
				4'd9, 4'd10, 4'd11: return 1'b1;
				4'd1, 4'd4, 4'd5:   return dir == DIR_PACK;
				default:            return 1'b0;
			endcase
		endfunction

		function void owe(logic [BYTE_W-1:0] b, logic [COEFF_W-1:0] c, logic l, logic e);
			packer_out_t r;
			r.byte_val = b;
			r.coeff_val = c;
			r.last = l;
			r.err = e;
			owed.push_back(r);
		endfunction

		function void note_item(logic [COEFF_W-1:0] c, logic [BYTE_W-1:0] b);
			logic [31:0] mask;
			logic [31:0] sx;
			logic [31:0] t;
			logic [31:0] work;
			logic [31:0] fld;
			logic [31:0] v;
			int unsigned have;
			logic        at_end;
			// unsupported setting: one error result, state untouched
			if (!supported()) begin
				owe('0, '0, 1'b0, 1'b1);
				return;
			end
			mask = (32'd1 << width) - 32'd1;
			if (dir == DIR_PACK) begin
				// append the masked field, emit whole bytes
				sx = {{(32-COEFF_W){c[COEFF_W-1]}}, c};
				t = ofs_mode ? (32'(ofs) - sx) : sx;
				t &= mask;
				work = 32'(acc) | (t << nbits);
				have = nbits + width;
				at_end = (ncoeff == LAST_IDX);
				while (have >= 8) begin
					fld = work & 32'hFF;
					work = work >> 8;
					have -= 8;
					owe(fld[BYTE_W-1:0], '0, at_end && (have == 0), 1'b0);
				end
				// final coefficient flushes a padded byte
				if (at_end) begin
					if (have > 0)
						owe(work[BYTE_W-1:0], '0, 1'b1, 1'b0);
					clear_stream();
				end else begin
					ncoeff = ncoeff + 1'b1;
					acc = work[ACC_W-1:0];
					nbits = have[CNT_W-1:0];
				end
			end else begin
				// append the byte, emit every completed field
				work = 32'(acc) | (32'(b) << nbits);
				have = nbits + 8;
				at_end = 1'b0;
				while (have >= width && !at_end) begin
					fld = work & mask;
					v = ofs_mode ? (32'(ofs) - fld) : fld;
					at_end = (ncoeff == LAST_IDX);
					work = work >> width;
					have -= width;
					owe('0, v[COEFF_W-1:0], at_end, 1'b0);
					if (!at_end)
						ncoeff = ncoeff + 1'b1;
				end
				// leftover bits after the final field are padding
				if (at_end) begin
					clear_stream();
				end else begin
					acc = work[ACC_W-1:0];
					nbits = have[CNT_W-1:0];
				end
			end
		endfunction

		function void check_result(logic [BYTE_W-1:0] b, logic [COEFF_W-1:0] c, logic l,
			logic e);
			packer_out_t want;
			results_seen++;
			if (l) lasts_seen++;
			if (e) errors_seen++;
			if (owed.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: byte %h coeff %h last %b err %b", b, c, l, e);
				return;
			end
			want = owed.pop_front();
			if (want.byte_val !== b || want.coeff_val !== c || want.last !== l ||
				want.err !== e) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected byte %h coeff %h last %b err %b,",
						want.byte_val, want.coeff_val, want.last, want.err,
						" got byte %h coeff %h last %b err %b", b, c, l, e);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	pcbp_feed_if   feed_ch();
	pcbp_result_if res_ch();
	pcbp_cfg_if    cfg_ch();

	poly_coeff_bit_packer dut (
		.clk    (clk),
		.arst_n (arst_n),
		.feed   (feed_ch),
		.result (res_ch),
		.cfg    (cfg_ch)
	);

	bitpack_predictor pred = new();

	rx_mode_t rx_mode = RX_ALWAYS;
	int       hold_request = 0;
	int       hold_left = 0;
	int       rx_tick = 0;
	bit       gapless = 1'b1;
	int       cycle_count = 0;
	int       items_sent = 0;
	int       settings_used = 0;

	always #6 clk = ~clk;

	// receiver stalls, with a long hold-off on request
	always @(negedge clk) begin
		rx_tick++;
		if (hold_request > 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			res_ch.ready = 1'b0;
			hold_left--;
		end else begin
			case (rx_mode)
				RX_ALWAYS: res_ch.ready = 1'b1;
				RX_RANDOM: res_ch.ready = ($urandom_range(0, 99) < 65);
				default:   res_ch.ready = (rx_tick % 5 != 0) && (rx_tick % 7 != 3);
			endcase
		end
	end

	// observe handshakes on all three channels
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_ch.valid && cfg_ch.ready)
				pred.write_reg(cfg_ch.index, cfg_ch.data);
			if (feed_ch.valid && feed_ch.ready)
				pred.note_item(feed_ch.coeff_in, feed_ch.byte_in);
			if (res_ch.valid && res_ch.ready)
				pred.check_result(res_ch.byte_out, res_ch.coeff_out, res_ch.last_of_poly,
					res_ch.config_error);
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("poly_coeff_bit_packer_test: done, errors");
			$finish;
		end
	end

	task automatic offer_item(logic [COEFF_W-1:0] c, logic [BYTE_W-1:0] b);
		@(negedge clk);
		feed_ch.valid = 1'b1;
		feed_ch.coeff_in = c;
		feed_ch.byte_in = b;
		@(posedge clk);
		while (!feed_ch.ready) @(posedge clk);
		items_sent++;
	endtask

	task automatic pause_feed(int n);
		repeat (n) begin
			@(negedge clk);
			feed_ch.valid = 1'b0;
		end
	endtask

	// stop sending and wait for every owed result plus pipeline slack
	task automatic drain_all();
		@(negedge clk);
		feed_ch.valid = 1'b0;
		while (pred.owed.size() != 0) @(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [OFS_W-1:0] d);
		@(negedge clk);
		cfg_ch.valid = 1'b1;
		cfg_ch.index = idx;
		cfg_ch.data = d;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	// unused upper data bits of the narrow registers get random values
	task automatic apply_setting(logic d, logic [FW_W-1:0] w, logic m, logic [OFS_W-1:0] o);
		drain_all();
		write_reg(REG_DIRECTION, {6'($urandom), d});
		write_reg(REG_FIELD_WIDTH, {3'($urandom), w});
		write_reg(REG_OFFSET_MODE, {6'($urandom), m});
		write_reg(REG_OFFSET_VALUE, o);
		settings_used++;
	endtask

	function automatic logic [COEFF_W-1:0] rand_coeff();
		case ($urandom_range(0, 9))
			0:       return 12'h800;
			1:       return 12'h7FF;
			2:       return 12'hFFF;
			3:       return 12'h000;
			default: return 12'($urandom);
		endcase
	endfunction

	// bursts of random length with random gaps unless gapless
	task automatic send_random(int n);
		int burst;
		burst = 0;
		for (int i = 0; i < n; i++) begin
			if (burst == 0) begin
				if (!gapless)
					pause_feed($urandom_range(0, 5));
				burst = $urandom_range(1, 12);
			end
			offer_item(rand_coeff(), 8'($urandom));
			burst--;
		end
	endtask

	// mostly supported settings, some arbitrary ones
	task automatic pick_setting();
		int               r;
		logic             d;
		logic [FW_W-1:0]  w;
		logic             m;
		logic [OFS_W-1:0] o;
		r = $urandom_range(0, 22);
		d = DIR_PACK;
		m = 1'b0;
		o = 7'($urandom);
		if (r < 6) begin
			case (r)
				0:       w = 4'd1;
				1:       w = 4'd4;
				2:       w = 4'd5;
				3:       w = 4'd9;
				4:       w = 4'd10;
				default: w = 4'd11;
			endcase
		end else if (r < 9) begin
			d = DIR_UNPACK;
			w = 4'(r + 3);
		end else if (r < 19) begin
			d = r[0];
			m = 1'b1;
			case ((r - 9) / 2)
				0:       begin w = 4'd2; o = OFS_ONE; end
				1:       begin w = 4'd2; o = OFS_TWO; end
				2:       begin w = 4'd5; o = OFS_16; end
				3:       begin w = 4'd6; o = OFS_32; end
				default: begin w = 4'd7; o = OFS_64; end
			endcase
		end else begin
			d = 1'($urandom);
			w = 4'($urandom);
			m = 1'($urandom);
		end
		apply_setting(d, w, m, o);
	endtask

	initial begin
		int rand_items;
		int round;
		int n;
		rand_items = 0;
		round = 0;
		feed_ch.valid = 1'b0;
		feed_ch.coeff_in = '0;
		feed_ch.byte_in = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_DIRECTION;
		cfg_ch.data = '0;
		res_ch.ready = 1'b1;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset setting: plain pack, width 9, coefficient extremes
		offer_item(12'h800, 8'h00);
		offer_item(12'h7FF, 8'hFF);
		offer_item(12'hFFF, 8'h5A);
		offer_item(12'h000, 8'hA5);

		// plain pack at widths 11, 1, 4 and 5, wide values get masked
		apply_setting(DIR_PACK, 4'd11, 1'b0, 7'd0);
		offer_item(12'h555, 8'h00);
		offer_item(12'hAAA, 8'hFF);
		apply_setting(DIR_PACK, 4'd1, 1'b0, 7'd0);
		offer_item(12'h001, 8'h00);
		offer_item(12'h800, 8'h00);
		apply_setting(DIR_PACK, 4'd4, 1'b0, 7'd0);
		offer_item(12'hFFF, 8'h00);
		apply_setting(DIR_PACK, 4'd5, 1'b0, 7'd0);
		offer_item(12'h7FF, 8'h00);

		// offset pack, every allowed pair
		apply_setting(DIR_PACK, 4'd2, 1'b1, OFS_ONE);
		offer_item(12'h800, 8'h00);
		offer_item(12'h7FF, 8'h00);
		apply_setting(DIR_PACK, 4'd2, 1'b1, OFS_TWO);
		offer_item(12'h001, 8'h00);
		apply_setting(DIR_PACK, 4'd5, 1'b1, OFS_16);
		offer_item(12'hFFF, 8'h00);
		apply_setting(DIR_PACK, 4'd6, 1'b1, OFS_32);
		offer_item(12'h020, 8'h00);
		apply_setting(DIR_PACK, 4'd7, 1'b1, OFS_64);
		offer_item(12'h800, 8'h00);
		offer_item(12'h7FF, 8'h00);

		// rejected combinations
		apply_setting(DIR_PACK, 4'd2, 1'b0, 7'd0);
		offer_item(12'h123, 8'h00);
		apply_setting(DIR_PACK, 4'd5, 1'b1, OFS_32);
		offer_item(12'h123, 8'h00);
		apply_setting(DIR_UNPACK, 4'd4, 1'b0, 7'd0);
		offer_item(12'h000, 8'h3C);
		apply_setting(DIR_PACK, 4'd15, 1'b0, 7'h7F);
		offer_item(12'h456, 8'h00);

		// unpack, plain and offset
		apply_setting(DIR_UNPACK, 4'd9, 1'b0, 7'd0);
		offer_item(12'h000, 8'h00);
		offer_item(12'h000, 8'hFF);
		offer_item(12'h000, 8'hA5);
		apply_setting(DIR_UNPACK, 4'd11, 1'b0, 7'd0);
		offer_item(12'h000, 8'hFF);
		offer_item(12'h000, 8'h5A);
		apply_setting(DIR_UNPACK, 4'd2, 1'b1, OFS_TWO);
		offer_item(12'h000, 8'hE4);
		apply_setting(DIR_UNPACK, 4'd7, 1'b1, OFS_64);
		offer_item(12'h000, 8'hFF);

		// random settings and content
		while (rand_items < RANDOM_ITEMS) begin
			n = $urandom_range(6, 30);
			pick_setting();
			rx_mode = rx_mode_t'($urandom_range(0, 2));
			gapless = ($urandom_range(0, 3) == 0);
			if (round == 2) begin
				// sender waits for all results mid-polynomial
				send_random(n / 2);
				drain_all();
				send_random(n - n / 2);
			end else begin
				send_random(n);
			end
			rand_items += n;
			round++;
		end

		// one whole polynomial unpacked at width 2, receiver held off at first
		apply_setting(DIR_UNPACK, 4'd2, 1'b1, OFS_ONE);
		rx_mode = RX_PATTERN;
		gapless = 1'b1;
		hold_request = HOLD_CYCLES;
		send_random(POLY_DEGREE * 2 / 8 + 6);

		drain_all();
		$display("covered %0d items over %0d register settings, %0d results checked",
			items_sent, settings_used, pred.results_seen);
		$display("%0d polynomial ends and %0d rejected-setting results seen",
			pred.lasts_seen, pred.errors_seen);
		if (pred.mismatches == 0 && pred.owed.size() == 0)
			$display("poly_coeff_bit_packer_test: done, clean");
		else
			$display("poly_coeff_bit_packer_test: done, errors");
		$finish;
	end

endmodule
